// ===== src/sdb_pkg.sv =====
`default_nettype none

package sdb_pkg;

    // Field widths fixed by the interface.
    localparam int ID_W       = 32;
    localparam int BUCKET_W   = 16;
    localparam int TOTAL_W    = 7;

    // Defaults and fixed constants.
    localparam int MAX_SUBCHUNKS_DEF = 64;
    localparam int RECORDS_PER_PAGE  = 64;   // must be a power of two
    localparam int PAGE_SHIFT        = $clog2(RECORDS_PER_PAGE);
    localparam int PAGE_SUM_W        = BUCKET_W + 1;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 16'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic setup;
        logic div_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_count;
        logic clamp;
        logic div_last;
        logic last_entry;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/subchunk_directory_builder_top.sv =====
// Subchunk directory builder.
// Input channel (i_valid / o_stall) carries one tile's item-id range per
// transaction. Output channel (o_valid / i_stall) carries one directory entry
// per transaction, one for each subchunk of the tile, in order. The bucket
// size register is written through i_cfg_valid / o_cfg_ready / i_cfg_data.
// Sequence: a tile is accepted, passes through a setup step, then the subchunk
// count is found by a restoring divider that produces one quotient bit per
// cycle in log2(MAX_SUBCHUNKS) steps, six by default (the divider is skipped
// for empty or clamped tiles). Entries then leave at one per cycle while the
// receiver does not stall. The next tile is accepted only once the last entry
// of the previous one is registered.
// Reset is synchronous and active low: it clears the page and directory
// cursors to zero, sets the bucket size to 256 and empties the output register.
// When the receiver stalls, the registered entry holds unchanged and the
// entry sequencer waits; nothing is dropped.

`default_nettype none

module subchunk_directory_builder_top #(
    parameter int MAX_SUBCHUNKS = sdb_pkg::MAX_SUBCHUNKS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [sdb_pkg::BUCKET_W-1:0]      i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [sdb_pkg::ID_W-1:0]          i_range_start,
    input  wire [sdb_pkg::ID_W-1:0]          i_range_end,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [sdb_pkg::ID_W-1:0]         o_tile_base,
    output logic [sdb_pkg::TOTAL_W-1:0]      o_subchunk_total,
    output logic [sdb_pkg::ID_W-1:0]         o_payload_prefix,
    output logic [sdb_pkg::ID_W-1:0]         o_entry_index,
    output logic [sdb_pkg::ID_W-1:0]         o_entry_page,
    output logic [sdb_pkg::BUCKET_W-1:0]     o_entry_length,
    output logic                             o_is_continuation,
    output logic                             o_last_of_tile,
    output logic                             o_clamped
);

    sdb_pkg::t_cmd w_cmd;
    sdb_pkg::t_sts w_sts;
    logic          w_cfg_we;

    // The register only takes a write while the controller is idle.
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    sdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_stall     (o_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    sdb_datapath #(
        .MAX_SUBCHUNKS (MAX_SUBCHUNKS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_range_start     (i_range_start),
        .i_range_end       (i_range_end),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_tile_base       (o_tile_base),
        .o_subchunk_total  (o_subchunk_total),
        .o_payload_prefix  (o_payload_prefix),
        .o_entry_index     (o_entry_index),
        .o_entry_page      (o_entry_page),
        .o_entry_length    (o_entry_length),
        .o_is_continuation (o_is_continuation),
        .o_last_of_tile    (o_last_of_tile),
        .o_clamped         (o_clamped)
    );

    // The subchunk count is always between one and the configured limit.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_subchunk_total != '0) &&
                    (o_subchunk_total <= sdb_pkg::TOTAL_W'(MAX_SUBCHUNKS)))
        else $error("subchunk total out of range");

    // An accepted tile always moves the controller into its setup step.
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_cmd.setup)
        else $error("accepted tile did not start setup");

    // A tile's first entry that is also its last belongs to a one-subchunk tile.
    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_tile && !o_is_continuation) |->
            (o_subchunk_total == sdb_pkg::TOTAL_W'(1)))
        else $error("single-entry tile with wrong total");

    // The first entry of a tile sits at the tile's directory base.
    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_continuation) |-> (o_entry_index == o_tile_base) &&
                                           (o_entry_page == o_payload_prefix))
        else $error("first entry does not match tile base");

endmodule

`default_nettype wire

// ===== src/sdb_ctrl.sv =====
`default_nettype none

module sdb_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  sdb_pkg::t_sts  i_sts,
    output sdb_pkg::t_cmd  o_cmd,
    output logic           o_stall,
    output logic           o_cfg_ready
);

    sdb_pkg::t_state r_state;
    sdb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sdb_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = sdb_pkg::ST_SETUP;
                end
            end
            sdb_pkg::ST_SETUP: begin
                if (i_sts.zero_count || i_sts.clamp) begin
                    n_state = sdb_pkg::ST_EMIT;
                end else begin
                    n_state = sdb_pkg::ST_DIV;
                end
            end
            sdb_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = sdb_pkg::ST_EMIT;
                end
            end
            sdb_pkg::ST_EMIT: begin
                if (i_sts.out_free && i_sts.last_entry) begin
                    n_state = sdb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_stall        = 1'b1;
        o_cfg_ready    = 1'b0;
        case (r_state)
            sdb_pkg::ST_IDLE: begin
                o_cmd.capture = i_valid;
                o_stall       = 1'b0;
                o_cfg_ready   = 1'b1;
            end
            sdb_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            sdb_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            sdb_pkg::ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sdb_datapath.sv =====
`default_nettype none

module sdb_datapath #(
    parameter int MAX_SUBCHUNKS = sdb_pkg::MAX_SUBCHUNKS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sdb_pkg::t_cmd                    i_cmd,
    output sdb_pkg::t_sts                    o_sts,
    input  wire                              i_cfg_we,
    input  wire [sdb_pkg::BUCKET_W-1:0]      i_cfg_data,
    input  wire [sdb_pkg::ID_W-1:0]          i_range_start,
    input  wire [sdb_pkg::ID_W-1:0]          i_range_end,
    input  wire                              i_stall,
    output logic                             o_valid,
    output logic [sdb_pkg::ID_W-1:0]         o_tile_base,
    output logic [sdb_pkg::TOTAL_W-1:0]      o_subchunk_total,
    output logic [sdb_pkg::ID_W-1:0]         o_payload_prefix,
    output logic [sdb_pkg::ID_W-1:0]         o_entry_index,
    output logic [sdb_pkg::ID_W-1:0]         o_entry_page,
    output logic [sdb_pkg::BUCKET_W-1:0]     o_entry_length,
    output logic                             o_is_continuation,
    output logic                             o_last_of_tile,
    output logic                             o_clamped
);

    localparam int IW   = sdb_pkg::ID_W;
    localparam int BW   = sdb_pkg::BUCKET_W;
    localparam int SCW  = $clog2(MAX_SUBCHUNKS + 1);
    localparam int QW   = (MAX_SUBCHUNKS > 1) ? $clog2(MAX_SUBCHUNKS) : 1;
    localparam int KW   = (QW > 1) ? $clog2(QW) : 1;
    localparam int LIMW = BW + SCW;
    localparam int PSW  = sdb_pkg::PAGE_SUM_W;

    logic [BW-1:0]  r_bucket;
    logic [IW-1:0]  r_page_cur;
    logic [IW-1:0]  r_dir_cur;
    logic [IW-1:0]  r_count;
    logic [IW-1:0]  r_left;
    logic [IW-1:0]  r_div;
    logic [QW-1:0]  r_q;
    logic [KW-1:0]  r_k;
    logic [SCW-1:0] r_total;
    logic [SCW-1:0] r_sc;
    logic           r_clamp;
    logic [IW-1:0]  r_base;
    logic [IW-1:0]  r_prefix;
    logic           r_out_valid;

    logic [BW-1:0]   w_bucket;
    logic [LIMW-1:0] w_limit;
    logic            w_clamp;
    logic            w_zero;
    logic [IW-1:0]   w_trial;
    logic            w_ge;
    logic [QW-1:0]   w_q_next;
    logic [BW-1:0]   w_len;
    logic [PSW-1:0]  w_page_sum;
    logic [PSW-1:0]  w_pages;
    logic            w_last;
    logic            w_out_free;

    // A bucket size of zero behaves as one.
    assign w_bucket = (r_bucket == '0) ? BW'(1) : r_bucket;
    assign w_limit  = LIMW'(MAX_SUBCHUNKS) * LIMW'(w_bucket);
    assign w_clamp  = r_count > IW'(w_limit);
    assign w_zero   = r_count == '0;

    // One restoring-division step: quotient bit r_k of (count - 1) / bucket.
    assign w_trial  = IW'(w_bucket) << r_k;
    assign w_ge     = r_div >= w_trial;
    assign w_q_next = w_ge ? (r_q | (QW'(1) << r_k)) : r_q;

    assign w_len      = (r_left > IW'(w_bucket)) ? w_bucket : r_left[BW-1:0];
    assign w_page_sum = PSW'(w_len) + PSW'(sdb_pkg::RECORDS_PER_PAGE - 1);
    assign w_pages    = w_page_sum >> sdb_pkg::PAGE_SHIFT;
    assign w_last     = (r_sc + SCW'(1)) == r_total;
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_sts.zero_count = w_zero;
    assign o_sts.clamp      = w_clamp;
    assign o_sts.div_last   = r_k == '0;
    assign o_sts.last_entry = w_last;
    assign o_sts.out_free   = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket    <= sdb_pkg::BUCKET_RESET;
            r_page_cur  <= '0;
            r_dir_cur   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bucket <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_page_cur  <= r_page_cur + IW'(w_pages);
                r_dir_cur   <= r_dir_cur + IW'(1);
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_count <= (i_range_end > i_range_start) ? (i_range_end - i_range_start) : '0;
        end
        if (i_cmd.setup) begin
            r_clamp  <= w_clamp;
            r_left   <= r_count;
            r_div    <= r_count - IW'(1);
            r_q      <= '0;
            r_k      <= KW'(QW - 1);
            r_sc     <= '0;
            r_base   <= r_dir_cur;
            r_prefix <= r_page_cur;
            if (w_zero) begin
                r_total <= SCW'(1);
            end else if (w_clamp) begin
                r_total <= SCW'(MAX_SUBCHUNKS);
            end
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_div <= r_div - w_trial;
            end
            r_q <= w_q_next;
            r_k <= r_k - KW'(1);
            if (r_k == '0) begin
                r_total <= SCW'(w_q_next) + SCW'(1);
            end
        end
        if (i_cmd.emit) begin
            r_left            <= r_left - IW'(w_len);
            r_sc              <= r_sc + SCW'(1);
            o_tile_base       <= r_base;
            o_subchunk_total  <= sdb_pkg::TOTAL_W'(r_total);
            o_payload_prefix  <= r_prefix;
            o_entry_index     <= r_dir_cur;
            o_entry_page      <= r_page_cur;
            o_entry_length    <= w_len;
            o_is_continuation <= r_sc != '0;
            o_last_of_tile    <= w_last;
            o_clamped         <= r_clamp;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
